FILE: rtl/cyclic_grid_min_path_macros.svh
// Assertion macros shared by the cyclic grid min path RTL.
`ifndef CYCLIC_GRID_MIN_PATH_MACROS_SVH
`define CYCLIC_GRID_MIN_PATH_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold on every clock edge out of reset.
`define CGMP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cgmp assertion failed");
// Condition a implies b in the next cycle.
`define CGMP_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("cgmp assertion failed");
`else
`define CGMP_ASSERT(lbl, prop)
`define CGMP_ASSERT_NEXT(lbl, a, b)
`endif
`endif

FILE: rtl/cgmp_pkg.sv
// Shared constants and types for the cyclic grid min path block.
package cgmp_pkg;

    localparam int MAX_ROWS_DEF = 16;
    localparam int MAX_COLS_DEF = 64;

    localparam int WEIGHT_W = 16;
    localparam int COST_W   = 22;
    localparam int ROW_W    = 5;
    localparam int NCOL_W   = 7;
    localparam int IDX_W    = 6;

    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    localparam logic [1:0] STEP_UP   = 2'd0;
    localparam logic [1:0] STEP_SAME = 2'd1;
    localparam logic [1:0] STEP_DOWN = 2'd2;

    typedef struct packed {
        logic                       last;
        logic [IDX_W-1:0]           row;
        logic [IDX_W-1:0]           col;
        logic signed [WEIGHT_W-1:0] weight;
    } cell_t;

endpackage

FILE: rtl/cgmp_front.sv
// Front end: accepts weight items and tags each with its grid position.
module cgmp_front #(
    parameter int MAX_ROWS = cgmp_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = cgmp_pkg::MAX_COLS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                clear,
    input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] rows_m1,
    input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] cols_m1,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic signed [cgmp_pkg::WEIGHT_W-1:0] weight,
    input  logic                                q_full,
    output logic                                q_push,
    output cgmp_pkg::cell_t                     q_cell
);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic          end_col, end_row;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign end_col  = (col_reg == cols_m1);
    assign end_row  = (row_reg == rows_m1);

    assign q_cell.last   = end_col && end_row;
    assign q_cell.row    = cgmp_pkg::IDX_W'(row_reg);
    assign q_cell.col    = cgmp_pkg::IDX_W'(col_reg);
    assign q_cell.weight = weight;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (clear)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (q_push)
        begin
            if (end_col)
            begin
                col_next = '0;
                row_next = end_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end
endmodule

FILE: rtl/cgmp_fifo.sv
// Short queue of tagged cells between front and back end.
module cgmp_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cgmp_pkg::cell_t push_cell,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output cgmp_pkg::cell_t pop_cell
);
    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    cgmp_pkg::cell_t mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     count_reg;

    assign full      = (count_reg == (PW+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cell  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cell;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

FILE: rtl/cgmp_back.sv
// Back end: grid store, column cost sweep, start row search and path emission.
`include "cyclic_grid_min_path_macros.svh"
module cgmp_back #(
    parameter int MAX_ROWS = cgmp_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = cgmp_pkg::MAX_COLS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] rows_m1,
    input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] cols_m1,
    input  logic                                q_valid,
    input  cgmp_pkg::cell_t                     q_cell,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cgmp_pkg::ROW_W-1:0]          path_row,
    output logic signed [cgmp_pkg::COST_W-1:0]  path_cost,
    output logic                                last
);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW = RW + CW;
    localparam int CAW = RW + 1;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_INIT_RD  = 11'b00000000010,
        S_INIT_WR  = 11'b00000000100,
        S_UP       = 11'b00000001000,
        S_SAME     = 11'b00000010000,
        S_DOWN     = 11'b00000100000,
        S_EVAL     = 11'b00001000000,
        S_MIN_RD   = 11'b00010000000,
        S_MIN_CMP  = 11'b00100000000,
        S_EMIT_RD  = 11'b01000000000,
        S_EMIT_OUT = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic [RW-1:0] r_reg, r_next, start_reg, start_next;
    logic [CW-1:0] c_reg, c_next;
    logic          bank_reg, bank_next, first_reg, first_next;
    logic signed [cgmp_pkg::COST_W-1:0] upv_reg, upv_next, samev_reg, samev_next;
    logic signed [cgmp_pkg::COST_W-1:0] best_reg, best_next;

    // grid, step choice and ping-pong cost memories
    logic signed [cgmp_pkg::WEIGHT_W-1:0] wmem [2**AW];
    logic [1:0]                           chmem [2**AW];
    logic signed [cgmp_pkg::COST_W-1:0]   cmem [2**CAW];
    logic signed [cgmp_pkg::WEIGHT_W-1:0] w_rdata_reg;
    logic [1:0]                           ch_rdata_reg;
    logic signed [cgmp_pkg::COST_W-1:0]   c_rdata_reg;

    logic [AW-1:0]  w_waddr, w_raddr, ch_addr;
    logic [CAW-1:0] c_raddr, c_waddr;
    logic           w_we, ch_we, c_we;
    logic signed [cgmp_pkg::COST_W-1:0] c_wdata;

    logic [RW-1:0] up_row, dn_row, emit_row_next;
    logic signed [cgmp_pkg::COST_W-1:0] bc0, bc1, bc2, bc3;
    logic [RW-1:0] br0, br1, br2, br3;
    logic [1:0]    bk0, bk1, bk2, bk3;

    logic out_valid_reg, out_valid_next, out_load;
    logic [cgmp_pkg::ROW_W-1:0] out_row_reg;
    logic signed [cgmp_pkg::COST_W-1:0] out_cost_reg;
    logic out_last_reg;

    assign up_row = (r_reg == '0) ? rows_m1 : r_reg - 1'b1;
    assign dn_row = (r_reg == rows_m1) ? '0 : r_reg + 1'b1;

    // candidate order up, same, down; ties go to the lower row
    always_comb
    begin
        bc0 = samev_reg;
        br0 = r_reg;
        bk0 = cgmp_pkg::STEP_SAME;
        bc1 = bc0; br1 = br0; bk1 = bk0;
        if (upv_reg < bc0 || (upv_reg == bc0 && up_row < br0))
        begin
            bc1 = upv_reg; br1 = up_row; bk1 = cgmp_pkg::STEP_UP;
        end
        bc2 = bc1; br2 = br1; bk2 = bk1;
        if (samev_reg < bc1 || (samev_reg == bc1 && r_reg < br1))
        begin
            bc2 = samev_reg; br2 = r_reg; bk2 = cgmp_pkg::STEP_SAME;
        end
        bc3 = bc2; br3 = br2; bk3 = bk2;
        if (c_rdata_reg < bc2 || (c_rdata_reg == bc2 && dn_row < br2))
        begin
            bc3 = c_rdata_reg; br3 = dn_row; bk3 = cgmp_pkg::STEP_DOWN;
        end
    end

    always_comb
    begin
        case (ch_rdata_reg)
            cgmp_pkg::STEP_UP:   emit_row_next = up_row;
            cgmp_pkg::STEP_DOWN: emit_row_next = dn_row;
            default:             emit_row_next = r_reg;
        endcase
    end

    assign q_pop   = (state_reg == S_IDLE) && q_valid;
    assign w_we    = q_pop;
    assign w_waddr = {q_cell.row[RW-1:0], q_cell.col[CW-1:0]};
    assign w_raddr = (state_reg == S_INIT_RD) ? {r_reg, cols_m1} : {r_reg, c_reg};
    assign ch_addr = {r_reg, c_reg};
    assign ch_we   = (state_reg == S_EVAL);
    assign c_we    = (state_reg == S_INIT_WR) || (state_reg == S_EVAL);
    assign c_waddr = (state_reg == S_EVAL) ? {!bank_reg, r_reg} : {bank_reg, r_reg};
    assign c_wdata = (state_reg == S_EVAL)
                   ? bc3 + cgmp_pkg::COST_W'(w_rdata_reg)
                   : cgmp_pkg::COST_W'(w_rdata_reg);

    always_comb
    begin
        unique case (state_reg)
            S_UP:    c_raddr = {bank_reg, up_row};
            S_DOWN:  c_raddr = {bank_reg, dn_row};
            default: c_raddr = {bank_reg, r_reg};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            wmem[w_waddr] <= q_cell.weight;
        end
        w_rdata_reg <= wmem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ch_we)
        begin
            chmem[ch_addr] <= bk3;
        end
        ch_rdata_reg <= chmem[ch_addr];
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            cmem[c_waddr] <= c_wdata;
        end
        c_rdata_reg <= cmem[c_raddr];
    end

    assign out_load = (state_reg == S_EMIT_OUT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        bank_next  = bank_reg;
        first_next = first_reg;
        start_next = start_reg;
        best_next  = best_reg;
        upv_next   = upv_reg;
        samev_next = samev_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_pop && q_cell.last)
                begin
                    r_next     = '0;
                    bank_next  = 1'b0;
                    state_next = S_INIT_RD;
                end
            end
            S_INIT_RD: state_next = S_INIT_WR;
            S_INIT_WR:
            begin
                if (r_reg == rows_m1)
                begin
                    r_next = '0;
                    if (cols_m1 == '0)
                    begin
                        first_next = 1'b1;
                        state_next = S_MIN_RD;
                    end
                    else
                    begin
                        c_next     = cols_m1 - 1'b1;
                        state_next = S_UP;
                    end
                end
                else
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = S_INIT_RD;
                end
            end
            S_UP: state_next = S_SAME;
            S_SAME:
            begin
                upv_next   = c_rdata_reg;
                state_next = S_DOWN;
            end
            S_DOWN:
            begin
                samev_next = c_rdata_reg;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (r_reg == rows_m1)
                begin
                    r_next    = '0;
                    bank_next = !bank_reg;
                    if (c_reg == '0)
                    begin
                        first_next = 1'b1;
                        state_next = S_MIN_RD;
                    end
                    else
                    begin
                        c_next     = c_reg - 1'b1;
                        state_next = S_UP;
                    end
                end
                else
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = S_UP;
                end
            end
            S_MIN_RD: state_next = S_MIN_CMP;
            S_MIN_CMP:
            begin
                first_next = 1'b0;
                if (first_reg || c_rdata_reg < best_reg)
                begin
                    best_next  = c_rdata_reg;
                    start_next = r_reg;
                end
                if (r_reg == rows_m1)
                begin
                    r_next     = start_next;
                    c_next     = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = S_MIN_RD;
                end
            end
            S_EMIT_RD: state_next = S_EMIT_OUT;
            S_EMIT_OUT:
            begin
                if (out_load)
                begin
                    if (c_reg == cols_m1)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        r_next     = emit_row_next;
                        c_next     = c_reg + 1'b1;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            r_reg         <= '0;
            c_reg         <= '0;
            bank_reg      <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            bank_reg      <= bank_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        best_reg  <= best_next;
        upv_reg   <= upv_next;
        samev_reg <= samev_next;
        if (out_load)
        begin
            out_row_reg  <= cgmp_pkg::ROW_W'(r_reg) + cgmp_pkg::ROW_W'(1);
            out_cost_reg <= best_reg;
            out_last_reg <= (c_reg == cols_m1);
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign path_row  = out_row_reg;
    assign path_cost = out_cost_reg;
    assign last      = out_last_reg;

    // row index may be stale while idle, after a size change
    `CGMP_ASSERT(a_pop_only_idle, !q_pop || state_reg == S_IDLE)
    `CGMP_ASSERT(a_row_in_range, state_reg == S_IDLE || r_reg <= rows_m1)
    `CGMP_ASSERT_NEXT(a_last_ends_grid, out_load && c_reg == cols_m1, state_reg == S_IDLE)
    `CGMP_ASSERT(a_cost_wr_bank, !(state_reg == S_EVAL) || c_waddr[RW] != c_raddr[RW])
endmodule

FILE: rtl/cyclic_grid_min_path.sv
// Top level of the cyclic grid minimum weight path engine.
// Weight items stream in row-major order, one per cycle while the queue is
// not full, into an on-chip grid store through a four-entry queue. Once the
// last cell of a num_rows x num_cols grid arrives, the back end sweeps the
// columns right to left with one shared compare unit: a read and a write per
// row seed the last column, and up, same, down and eval steps handle each
// cell of every other column (one cost memory read port serves the up, same
// and down neighbors); a read and a compare per row then pick the start row.
// Meanwhile new weight items fill the queue and then stall until the back end
// is idle again. One result item goes out per column: row (from one), total
// path cost, and tlast on the final column. Ties always pick the lower row. Writing
// any register drops a partly loaded grid; write registers only while idle.
module cyclic_grid_min_path #(
    parameter int MAX_ROWS = cgmp_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = cgmp_pkg::MAX_COLS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // weight items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] weight
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [4:0] path_row, [26:5] path_cost, rest zero
    output logic        m_tlast
);
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [cgmp_pkg::ROW_W-1:0]  num_rows_reg, num_rows_next;
    logic [cgmp_pkg::NCOL_W-1:0] num_cols_reg, num_cols_next;
    logic [cgmp_pkg::ROW_W-1:0]  wr_rows;
    logic [cgmp_pkg::NCOL_W-1:0] wr_cols;
    logic                        cfg_wr;
    logic [RW-1:0]               rows_m1;
    logic [CW-1:0]               cols_m1;

    logic            q_full, q_push, q_pop, q_valid;
    cgmp_pkg::cell_t push_cell, pop_cell;

    logic [cgmp_pkg::ROW_W-1:0]         path_row;
    logic signed [cgmp_pkg::COST_W-1:0] path_cost;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // clamp sizes: zero reads as one, above the maximum reads as the maximum
    assign wr_rows = (pwdata[4:0] == '0) ? cgmp_pkg::ROW_W'(1)
                   : ((32'(pwdata[4:0]) > 32'(MAX_ROWS)) ? cgmp_pkg::ROW_W'(MAX_ROWS)
                                                         : pwdata[4:0]);
    assign wr_cols = (pwdata[6:0] == '0) ? cgmp_pkg::NCOL_W'(1)
                   : ((32'(pwdata[6:0]) > 32'(MAX_COLS)) ? cgmp_pkg::NCOL_W'(MAX_COLS)
                                                         : pwdata[6:0]);

    always_comb
    begin
        num_rows_next = num_rows_reg;
        num_cols_next = num_cols_reg;
        if (cfg_wr && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[2])
                cgmp_pkg::REG_NUM_ROWS: num_rows_next = wr_rows;
                cgmp_pkg::REG_NUM_COLS: num_cols_next = wr_cols;
                default:                num_rows_next = num_rows_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= cgmp_pkg::ROW_W'(1);
            num_cols_reg <= cgmp_pkg::NCOL_W'(1);
        end
        else
        begin
            num_rows_reg <= num_rows_next;
            num_cols_reg <= num_cols_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            cgmp_pkg::REG_NUM_ROWS: prdata = 32'(num_rows_reg);
            cgmp_pkg::REG_NUM_COLS: prdata = 32'(num_cols_reg);
            default:                prdata = '0;
        endcase
    end

    assign rows_m1 = RW'(num_rows_reg - cgmp_pkg::ROW_W'(1));
    assign cols_m1 = CW'(num_cols_reg - cgmp_pkg::NCOL_W'(1));

    cgmp_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (cfg_wr),
        .rows_m1  (rows_m1),
        .cols_m1  (cols_m1),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .weight   (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cell   (push_cell)
    );

    cgmp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cell (push_cell),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_cell  (pop_cell)
    );

    cgmp_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rows_m1   (rows_m1),
        .cols_m1   (cols_m1),
        .q_valid   (q_valid),
        .q_cell    (pop_cell),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .path_row  (path_row),
        .path_cost (path_cost),
        .last      (m_tlast)
    );

    assign m_tdata = {5'b0, path_cost, path_row};
endmodule
